### design/tsc_pkg.sv
// Shared types, constants and helper functions for the Taylor sine/cosine core.
// Used by every module of the core; depends on nothing.

package tsc_pkg;

  localparam int COEF_COUNT = 20;

  typedef logic signed [30:0] angle_t;  // Q3.28
  typedef logic signed [31:0] q30_t;    // Q2.30
  typedef logic        [31:0] ysq_t;    // x*x in Q4.28, never negative

  localparam angle_t ANGLE_MAX = 31'sd843314857;
  localparam angle_t ANGLE_MIN = -31'sd843314857;

  localparam logic signed [39:0] SAT_HI = 40'sd2147483647;
  localparam logic signed [39:0] SAT_LO = -40'sd2147483648;

  // Data handed from cell to cell.
  typedef struct packed {
    logic   odd;   // 1: sine series (odd powers)
    angle_t x;
    ysq_t   y;
    q30_t   acc;
  } stage_t;

  // Horner coefficient of one cell for both series.
  typedef struct packed {
    q30_t even;
    q30_t odd;
  } coef_pair_t;

  // 1/n! in Q2.30, rounded to nearest; zero from n = 13 on.
  function automatic q30_t inv_fact(int n);
    q30_t c;
    case (n)
      0:       c = 32'sd1073741824;
      1:       c = 32'sd1073741824;
      2:       c = 32'sd536870912;
      3:       c = 32'sd178956971;
      4:       c = 32'sd44739243;
      5:       c = 32'sd8947849;
      6:       c = 32'sd1491308;
      7:       c = 32'sd213044;
      8:       c = 32'sd26631;
      9:       c = 32'sd2959;
      10:      c = 32'sd296;
      11:      c = 32'sd27;
      12:      c = 32'sd2;
      default: c = '0;
    endcase
    return c;
  endfunction

  // (-1)^term / (2*term + odd)!
  function automatic q30_t coef_q30(int term, logic odd);
    int   n;
    q30_t c;
    n = 2 * term + int'(odd);
    c = (n < COEF_COUNT) ? inv_fact(n) : '0;
    return term[0] ? -c : c;
  endfunction

  // Clip to the signed 32-bit range.
  function automatic q30_t sat_q30(logic signed [39:0] v);
    q30_t r;
    if (v > SAT_HI) begin
      r = 32'sh7fff_ffff;
    end else if (v < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### design/taylor_sin_cos_core.sv
// Top level of the Taylor-series sine/cosine core: front cell, Horner cell chain, output cell.
// Depends on tsc_pkg, tsc_front, tsc_cell and tsc_out.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | in_valid_i, in_stall_o,              | into core
//           | in_func_i, in_angle_i                |
//   out     | out_valid_o, out_stall_i, out_value_o| out of core
//
// Flow: one transfer per cycle on each side while neither side stalls; a result
// passes the front cell, TERMS-1 Horner cells and the output cell. Each cell holds one
// multiplier, which sets the clock period.
// Reset: asynchronous, active low; clears the valid flags of all cells.
// Stalls: each cell loads whenever it is empty or the cell after it loads,
// so bubbles close up while the output is stalled and new transfers keep
// coming in until every cell is full.

module taylor_sin_cos_core #(
  parameter int TERMS = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            in_func_i,
  input  tsc_pkg::angle_t in_angle_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output tsc_pkg::q30_t   out_value_o
);
  import tsc_pkg::*;

  localparam int NCELL = TERMS - 1;  // Horner cells

  // index 0: front cell, 1..NCELL: Horner cells, NCELL+1: output cell
  logic   vld [NCELL+2];
  logic   en  [NCELL+2];
  stage_t data [NCELL+1];

  // Load enables ripple back from the output.
  assign en[NCELL+1] = !vld[NCELL+1] || !out_stall_i;
  for (genvar k = 0; k <= NCELL; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  assign in_stall_o = !en[0];

  // Front cell starts Horner's rule with the highest-order coefficient.
  localparam coef_pair_t COEF_TOP = '{even: coef_q30(TERMS - 1, 1'b0),
                                      odd:  coef_q30(TERMS - 1, 1'b1)};

  tsc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[0]),
    .valid_i (in_valid_i),
    .func_i  (in_func_i),
    .angle_i (in_angle_i),
    .coef_i  (COEF_TOP),
    .valid_o (vld[0]),
    .data_o  (data[0])
  );

  // Cell k folds in term TERMS-1-k.
  for (genvar k = 1; k <= NCELL; k++) begin : g_cell
    localparam coef_pair_t COEF = '{even: coef_q30(TERMS - 1 - k, 1'b0),
                                    odd:  coef_q30(TERMS - 1 - k, 1'b1)};
    tsc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[k]),
      .valid_i (vld[k-1]),
      .data_i  (data[k-1]),
      .coef_i  (COEF),
      .valid_o (vld[k]),
      .data_o  (data[k])
    );
  end

  tsc_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[NCELL+1]),
    .valid_i (vld[NCELL]),
    .data_i  (data[NCELL]),
    .valid_o (vld[NCELL+1]),
    .value_o (out_value_o)
  );

  assign out_valid_o = vld[NCELL+1];

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------

  // An idle output side never holds back the input.
  a_no_stall_when_drained : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o
  ) else $error("input stalled while output side is free");

  // An input transfer always lands in the front cell.
  a_front_loaded : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld[0]
  ) else $error("accepted transfer lost in front cell");

  // With the output stalled, a filled front cell next to a waiting result
  // and an input stall must agree: stall only when the front cell cannot move.
  a_stall_means_front_full : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (vld[0] && out_valid_o && out_stall_i)
  ) else $error("input stalled with room in the chain");

endmodule

### design/tsc_front.sv
// Front cell of the Taylor sine/cosine chain: angle clamp, x squared, first coefficient.
// Depends on tsc_pkg.

module tsc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic                func_i,
  input  tsc_pkg::angle_t     angle_i,
  input  tsc_pkg::coef_pair_t coef_i,
  output logic                valid_o,
  output tsc_pkg::stage_t     data_o
);
  import tsc_pkg::*;

  angle_t             x_clamp;
  logic signed [61:0] sq;
  logic signed [61:0] sq_rnd;
  stage_t             data_d;
  stage_t             data_q;
  logic               valid_q;

  always_comb begin
    if (angle_i > ANGLE_MAX) begin
      x_clamp = ANGLE_MAX;
    end else if (angle_i < ANGLE_MIN) begin
      x_clamp = ANGLE_MIN;
    end else begin
      x_clamp = angle_i;
    end
  end

  // x*x < 2^60 after the clamp, so bits 59:28 hold the rounded square.
  assign sq     = x_clamp * x_clamp;
  assign sq_rnd = sq + 62'sd134217728;

  always_comb begin
    data_d.odd = ~func_i;
    data_d.x   = x_clamp;
    data_d.y   = sq_rnd[59:28];
    data_d.acc = func_i ? coef_i.even : coef_i.odd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/tsc_cell.sv
// One Horner cell: acc <= sat(coef + round(acc * y >> 28)).
// Depends on tsc_pkg.

module tsc_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  tsc_pkg::stage_t     data_i,
  input  tsc_pkg::coef_pair_t coef_i,
  output logic                valid_o,
  output tsc_pkg::stage_t     data_o
);
  import tsc_pkg::*;

  logic signed [64:0] prod;
  logic signed [64:0] prod_rnd;
  logic signed [39:0] sum;
  q30_t               coef;
  stage_t             data_d;
  stage_t             data_q;
  logic               valid_q;

  assign coef     = data_i.odd ? coef_i.odd : coef_i.even;
  assign prod     = data_i.acc * $signed({1'b0, data_i.y});
  assign prod_rnd = prod + 65'sd134217728;
  // upper bits of the two's complement word give the floor of the shift
  assign sum      = {{3{prod_rnd[64]}}, prod_rnd[64:28]} + {{8{coef[31]}}, coef};

  always_comb begin
    data_d     = data_i;
    data_d.acc = sat_q30(sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/tsc_out.sv
// Output cell: final multiply by x for sine, pass-through for cosine, output register.
// Depends on tsc_pkg.

module tsc_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  tsc_pkg::stage_t data_i,
  output logic            valid_o,
  output tsc_pkg::q30_t   value_o
);
  import tsc_pkg::*;

  logic signed [62:0] prod;
  logic signed [62:0] prod_rnd;
  q30_t               value_d;
  q30_t               value_q;
  logic               valid_q;

  assign prod     = data_i.x * data_i.acc;
  assign prod_rnd = prod + 63'sd134217728;
  assign value_d  = data_i.odd ? sat_q30({{5{prod_rnd[62]}}, prod_rnd[62:28]}) : data_i.acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= value_d;
    end
  end

  assign valid_o = valid_q;
  assign value_o = value_q;

endmodule
